// File: sv/csv_field_splitter_unit_macros.svh
// Assertion macros for the CSV splitter.
`ifndef CSV_FIELD_SPLITTER_UNIT_MACROS_SVH
`define CSV_FIELD_SPLITTER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CSVFS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("csvfs assertion failed");

// Next-cycle implication, checked out of reset.
`define CSVFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("csvfs assertion failed");

`endif

// File: sv/csvfs_pkg.sv
`default_nettype none

package csvfs_pkg;

    localparam int BYTE_W    = 8;
    localparam int FIDX_W    = 5;
    localparam int FCOUNT_W  = 6;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    localparam logic [BYTE_W-1:0] CHAR_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;

    // one result transaction
    typedef struct packed {
        logic                has_char;
        logic [BYTE_W-1:0]   char_byte;
        logic                space_before;
        logic [FIDX_W-1:0]   field_index;
        logic                field_end;
        logic                record_end;
        logic [FCOUNT_W-1:0] field_count;
        logic                overflow;
    } csvfs_res_t;

endpackage

`default_nettype wire

// File: sv/csv_field_splitter_unit.sv
`default_nettype none

// CSV field splitter: takes one byte of a CSV line per transaction (tlast marks the
// last byte of the line) and returns one result transaction for each stored field
// character, each closed field and each line end (a byte that does several of these
// still yields a single transaction); quotes, blanks, separators past the MAX_FIELDS
// budget and line terminators outside quotes produce nothing unless they carry tlast.
// A byte is taken every clock while the result side keeps up: the byte is held in an
// input register, the parse step runs on it in the next cycle against the parser
// state, and the result is loaded into an output register once that register has
// room, which raises m_tvalid. Bytes that produce no result never wait on the
// master side. The overflow bit is sticky until reset and reports a field that needs
// more than MAX_FIELD_LEN-1 slots (a kept blank run takes one) or fields beyond MAX_FIELDS per line.
module csv_field_splitter_unit
    import csvfs_pkg::*;
#(
    parameter int MAX_FIELDS    = 32,
    parameter int MAX_FIELD_LEN = 128
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // slave side: incoming characters
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [BYTE_W-1:0]    s_tdata,   // [7:0] in_byte
    input  wire logic                 s_tlast,   // end_of_record
    // master side: parse results
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // [7:0] char_byte, [8] space_before,
                                                 // [13:9] field_index, [19:14] field_count,
                                                 // [20] overflow, [23:21] zero
    output logic [M_TUSER_W-1:0]      m_tuser,   // [0] has_char, [1] field_end
    output logic                      m_tlast    // record_end
);

    // input stage
    logic              stage_valid_reg, stage_valid_next;
    logic [BYTE_W-1:0] stage_byte_reg;
    logic              stage_eor_reg;

    logic       stage_go;
    logic       res_valid;
    logic       out_free;
    csvfs_res_t res;
    csvfs_res_t m_res;

    // a byte moves on when it yields nothing or the result register has room
    assign stage_go = stage_valid_reg && (!res_valid || out_free);
    assign s_tready = !stage_valid_reg || stage_go;

    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (s_tready) begin
            stage_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            stage_byte_reg <= s_tdata;
            stage_eor_reg  <= s_tlast;
        end
    end

    csvfs_core #(
        .MAX_FIELDS    (MAX_FIELDS),
        .MAX_FIELD_LEN (MAX_FIELD_LEN)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .go            (stage_go),
        .in_byte       (stage_byte_reg),
        .end_of_record (stage_eor_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    csvfs_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (stage_go && res_valid),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    // pack the result transaction
    assign m_tdata = {3'b000, m_res.overflow, m_res.field_count, m_res.field_index,
                      m_res.space_before, m_res.char_byte};
    assign m_tuser = {m_res.field_end, m_res.has_char};
    assign m_tlast = m_res.record_end;

endmodule

`default_nettype wire

// File: sv/csvfs_core.sv
`default_nettype none

`include "csv_field_splitter_unit_macros.svh"

// Parser state and per-byte step logic.
module csvfs_core
    import csvfs_pkg::*;
#(
    parameter int MAX_FIELDS    = 32,
    parameter int MAX_FIELD_LEN = 128
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              go,          // commit the staged byte
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic              end_of_record,
    output logic                   res_valid,
    output csvfs_res_t             res
);

    localparam int FIELD_W = $clog2(MAX_FIELDS + 1);
    localparam int LEN_W   = (MAX_FIELD_LEN > 2) ? $clog2(MAX_FIELD_LEN) : 1;
    localparam logic [FIELD_W-1:0] FIELD_LIMIT = FIELD_W'(MAX_FIELDS);
    localparam logic [LEN_W:0]     LEN_LIMIT   = (LEN_W + 1)'(MAX_FIELD_LEN - 1);

    logic               in_quotes_reg, in_quotes_next;
    logic [FIELD_W-1:0] cur_field_reg, cur_field_next;
    logic [LEN_W-1:0]   field_len_reg, field_len_next;
    logic               space_pend_reg, space_pend_next;
    logic               overflow_reg, overflow_next;

    logic               has;
    logic               fe;
    logic [FIELD_W-1:0] fidx;
    logic [FIELD_W-1:0] count;
    logic [LEN_W:0]     len_sum;
    logic [FIELD_W+FIDX_W-1:0]   fidx_ext;
    logic [FIELD_W+FCOUNT_W-1:0] count_ext;

    always_comb begin
        in_quotes_next  = in_quotes_reg;
        cur_field_next  = cur_field_reg;
        field_len_next  = field_len_reg;
        space_pend_next = space_pend_reg;
        overflow_next   = overflow_reg;
        has  = 1'b0;
        fe   = 1'b0;
        fidx = '0;
        len_sum = {1'b0, field_len_reg} + (space_pend_reg ? (LEN_W + 1)'(2)
                                                          : (LEN_W + 1)'(1));

        if (in_byte == CHAR_QUOTE) begin
            in_quotes_next = !in_quotes_reg;
        end else if (!in_quotes_reg && in_byte == CHAR_COMMA) begin
            if (cur_field_reg < FIELD_LIMIT) begin
                fe             = 1'b1;
                fidx           = cur_field_reg;
                cur_field_next = cur_field_reg + FIELD_W'(1);
            end else begin
                overflow_next = 1'b1;
            end
            field_len_next  = '0;
            space_pend_next = 1'b0;
        end else if (!in_quotes_reg && (in_byte == CHAR_CR || in_byte == CHAR_LF)) begin
            // line terminators outside quotes carry nothing
        end else if (in_byte == CHAR_SPACE || in_byte == CHAR_TAB) begin
            if (field_len_reg != '0) begin
                space_pend_next = 1'b1;
            end
        end else begin
            if (cur_field_reg < FIELD_LIMIT && len_sum <= LEN_LIMIT) begin
                has            = 1'b1;
                fidx           = cur_field_reg;
                field_len_next = len_sum[LEN_W-1:0];
            end else begin
                overflow_next = 1'b1;
            end
            space_pend_next = 1'b0;
        end

        count = cur_field_next;
        if (end_of_record) begin
            // last field counts only if it holds something
            if (field_len_next != '0 && cur_field_next < FIELD_LIMIT) begin
                fe    = 1'b1;
                fidx  = cur_field_next;
                count = cur_field_next + FIELD_W'(1);
            end
            in_quotes_next  = 1'b0;
            cur_field_next  = '0;
            field_len_next  = '0;
            space_pend_next = 1'b0;
        end
    end

    assign fidx_ext  = {{FIDX_W{1'b0}}, fidx};
    assign count_ext = {{FCOUNT_W{1'b0}}, count};

    always_comb begin
        res_valid        = has || fe || end_of_record;
        res.has_char     = has;
        res.char_byte    = has ? in_byte : '0;
        res.space_before = has && space_pend_reg;
        res.field_index  = fidx_ext[FIDX_W-1:0];
        res.field_end    = fe;
        res.record_end   = end_of_record;
        res.field_count  = count_ext[FCOUNT_W-1:0];
        res.overflow     = overflow_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_quotes_reg  <= 1'b0;
            cur_field_reg  <= '0;
            field_len_reg  <= '0;
            space_pend_reg <= 1'b0;
            overflow_reg   <= 1'b0;
        end else if (go) begin
            in_quotes_reg  <= in_quotes_next;
            cur_field_reg  <= cur_field_next;
            field_len_reg  <= field_len_next;
            space_pend_reg <= space_pend_next;
            overflow_reg   <= overflow_next;
        end
    end

    `CSVFS_ASSERT_NEXT(a_eor_rearms, go && end_of_record,
        !in_quotes_reg && cur_field_reg == '0 && field_len_reg == '0 && !space_pend_reg)
    `CSVFS_ASSERT_NEXT(a_overflow_sticky, overflow_reg, overflow_reg)
    `CSVFS_ASSERT_NOW(a_field_bound, 1'b1, cur_field_reg <= FIELD_LIMIT)
    `CSVFS_ASSERT_NOW(a_char_and_end, has && fe, end_of_record)

endmodule

`default_nettype wire

// File: sv/csvfs_out_reg.sv
`default_nettype none

// Result register on the master side.
module csvfs_out_reg
    import csvfs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  wire csvfs_res_t  res,
    output logic             out_free,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output csvfs_res_t       m_res
);

    logic       valid_reg, valid_next;
    csvfs_res_t data_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = data_reg;

endmodule

`default_nettype wire

// File: dv/csv_field_splitter_unit_test.sv
`timescale 1ns / 100ps

// Bench for the CSV field splitter. Bytes go in on the slave side, one transaction
// per byte with tlast on the last byte of a line. Every accepted byte is run through
// a local line parser, and its forecast is queued (directed rows may type the result
// or expect none). Master-side results are checked field by field against the oldest entry.
module csv_field_splitter_unit_test
    import csvfs_pkg::*;
();

    localparam int FIELD_LIMIT = 32;
    localparam int LEN_LIMIT   = 128;
    localparam int CLK_HALF    = 4;          // 8 ns period
    localparam int RAND_BYTES  = 1050;
    localparam int CYCLE_LIMIT = 250000;
    localparam int CALM_FROM   = 600;        // no idling on either side in this window
    localparam int CALM_TO     = 1600;

    // how a row of the directed table is checked
    typedef enum logic [1:0] {
        ROW_PREDICT,    // expectation from the parser model
        ROW_NONE,       // no result transaction expected
        ROW_RES         // result typed into the table
    } row_kind_e;

    typedef struct {
        logic [BYTE_W-1:0] b;
        logic              last;
        row_kind_e         kind;
        csvfs_res_t        res;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    // parser model state, mirrors the line state of the block
    bit in_quote;
    int cur_field;
    int field_len;
    bit blank_pending;
    bit overflow_seen;

    csvfs_res_t expected_results[$];
    int         mismatches;
    int         cyc;
    int         rand_sent;
    logic [BYTE_W-1:0] line_bytes[$];

    csv_field_splitter_unit #(
        .MAX_FIELDS    (FIELD_LIMIT),
        .MAX_FIELD_LEN (LEN_LIMIT)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Cycle count doubles as the watchdog.
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Random idling, switched off inside the calm window so that the block also
    // sees long back-to-back stretches.
    function automatic bit take_break();
        if (cyc >= CALM_FROM && cyc < CALM_TO)
            return 1'b0;
        return $urandom_range(99) < 38;
    endfunction

    always @(posedge aclk) begin
        m_tready <= !take_break();
    end

    function automatic csvfs_res_t mk_res(bit has, logic [7:0] ch, bit sp, int fidx,
                                          bit fe, bit re, int cnt, bit ovf);
        csvfs_res_t r;
        r.has_char     = has;
        r.char_byte    = ch;
        r.space_before = sp;
        r.field_index  = fidx[FIDX_W-1:0];
        r.field_end    = fe;
        r.record_end   = re;
        r.field_count  = cnt[FCOUNT_W-1:0];
        r.overflow     = ovf;
        return r;
    endfunction

    // Parse step for one accepted byte. Returns 1 when the byte yields a result
    // transaction, which is then left in r.
    function automatic bit split_byte(input logic [7:0] b, input logic last,
                                      output csvfs_res_t r);
        bit         has;
        bit         sp;
        bit         fe;
        logic [7:0] ch;
        int         fidx;
        int         cnt;
        int         need;
        has  = 1'b0;
        sp   = 1'b0;
        fe   = 1'b0;
        ch   = '0;
        fidx = 0;
        if (b == CHAR_QUOTE) begin
            in_quote = !in_quote;
        end else if (!in_quote && b == CHAR_COMMA) begin
            // separator: closes the field unless the field budget is spent
            if (cur_field < FIELD_LIMIT) begin
                fe   = 1'b1;
                fidx = cur_field;
                cur_field++;
            end else begin
                overflow_seen = 1'b1;
            end
            field_len     = 0;
            blank_pending = 1'b0;
        end else if (!in_quote && (b == CHAR_CR || b == CHAR_LF)) begin
            // line terminators outside quotes vanish
        end else if (b == CHAR_SPACE || b == CHAR_TAB) begin
            if (field_len > 0)
                blank_pending = 1'b1;
        end else begin
            // stored character; a collapsed space costs one extra slot
            need = blank_pending ? 2 : 1;
            if (cur_field < FIELD_LIMIT && field_len + need <= LEN_LIMIT - 1) begin
                has       = 1'b1;
                ch        = b;
                sp        = blank_pending;
                fidx      = cur_field;
                field_len += need;
            end else begin
                overflow_seen = 1'b1;
            end
            blank_pending = 1'b0;
        end
        cnt = cur_field;
        if (last) begin
            // final field only counts when something was stored in it
            if (field_len > 0 && cur_field < FIELD_LIMIT) begin
                fe   = 1'b1;
                fidx = cur_field;
                cnt  = cur_field + 1;
            end
            in_quote      = 1'b0;
            cur_field     = 0;
            field_len     = 0;
            blank_pending = 1'b0;
        end
        r = mk_res(has, ch, sp, fidx, fe, last, cnt, overflow_seen);
        return has || fe || last;
    endfunction

    // Drives one byte and waits until it is accepted. The model is stepped at the
    // accepting edge; typed rows replace its forecast but never its state update.
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input row_kind_e kind, input csvfs_res_t typed);
        csvfs_res_t r;
        bit         yields;
        while (take_break()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        yields = split_byte(b, last, r);
        case (kind)
            ROW_PREDICT: begin
                if (yields)
                    expected_results.push_back(r);
            end
            ROW_RES: begin
                expected_results.push_back(typed);
            end
            default: begin
            end
        endcase
    endtask

    // Sends the assembled line, tlast on its final byte.
    task automatic send_line();
        foreach (line_bytes[i]) begin
            send_byte(line_bytes[i], i == line_bytes.size() - 1, ROW_PREDICT, '0);
            rand_sent++;
        end
        line_bytes.delete();
    endtask

    task automatic push_blanks(input int n);
        repeat (n)
            line_bytes.push_back($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
    endtask

    // Field body: text with blank runs inside; quoted bodies also carry separators
    // and line terminators as data.
    task automatic push_text(input int n, input bit quoted);
        int k;
        repeat (n) begin
            k = $urandom_range(9);
            if (k == 0) begin
                push_blanks($urandom_range(1, 3));
            end else if (k == 1) begin
                if (quoted)
                    case ($urandom_range(2))
                        0:       line_bytes.push_back(CHAR_COMMA);
                        1:       line_bytes.push_back(CHAR_CR);
                        default: line_bytes.push_back(CHAR_LF);
                    endcase
                else
                    line_bytes.push_back(8'($urandom_range(128, 255)));
            end else if (k < 4) begin
                line_bytes.push_back(8'($urandom_range(8'h30, 8'h39)));
            end else begin
                line_bytes.push_back(8'($urandom_range(8'h41, 8'h7A)));
            end
        end
    endtask

    // Result side: every accepted transaction is matched with the oldest queued expectation.
    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        csvfs_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, tdata %h tuser %b tlast %b",
                         $time, m_tdata, m_tuser, m_tlast);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("char_byte",    want.char_byte,    m_tdata[7:0]);
                check_field("space_before", want.space_before, m_tdata[8]);
                check_field("field_index",  want.field_index,  m_tdata[13:9]);
                check_field("field_count",  want.field_count,  m_tdata[19:14]);
                check_field("overflow",     want.overflow,     m_tdata[20]);
                check_field("tdata pad",    0,                 m_tdata[23:21]);
                check_field("has_char",     want.has_char,     m_tuser[0]);
                check_field("field_end",    want.field_end,    m_tuser[1]);
                check_field("record_end",   want.record_end,   m_tlast);
            end
        end
    end

    stim_row_t dir_tab[20];

    initial begin
        int        kind;
        int        nfld;
        bit        quoted;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        rand_sent     = 0;
        in_quote      = 1'b0;
        cur_field     = 0;
        field_len     = 0;
        blank_pending = 1'b0;
        overflow_seen = 1'b0;

        // Directed lines straight after reset: blank handling, quoting, separators,
        // terminators, byte extremes, an unclosed quote and empty lines.
        dir_tab = '{
            '{8'h41,      1'b0, ROW_RES,     mk_res(1, 8'h41, 0, 0, 0, 0, 0, 0)},
            '{CHAR_SPACE, 1'b0, ROW_NONE,    '0},
            '{CHAR_TAB,   1'b0, ROW_NONE,    '0},
            '{8'hFF,      1'b0, ROW_RES,     mk_res(1, 8'hFF, 1, 0, 0, 0, 0, 0)},
            '{CHAR_COMMA, 1'b0, ROW_RES,     mk_res(0, 8'h00, 0, 0, 1, 0, 1, 0)},
            '{CHAR_QUOTE, 1'b0, ROW_NONE,    '0},
            '{CHAR_COMMA, 1'b0, ROW_PREDICT, '0},
            '{CHAR_CR,    1'b0, ROW_PREDICT, '0},
            '{CHAR_LF,    1'b0, ROW_PREDICT, '0},
            '{CHAR_QUOTE, 1'b0, ROW_NONE,    '0},
            '{CHAR_CR,    1'b0, ROW_NONE,    '0},
            '{8'h00,      1'b0, ROW_PREDICT, '0},
            '{CHAR_SPACE, 1'b0, ROW_NONE,    '0},
            '{CHAR_COMMA, 1'b0, ROW_RES,     mk_res(0, 8'h00, 0, 1, 1, 0, 2, 0)},
            '{CHAR_SPACE, 1'b0, ROW_NONE,    '0},
            // quote left open at line end is dropped, empty last field not counted
            '{CHAR_QUOTE, 1'b1, ROW_RES,     mk_res(0, 8'h00, 0, 0, 0, 1, 2, 0)},
            '{CHAR_COMMA, 1'b0, ROW_RES,     mk_res(0, 8'h00, 0, 0, 1, 0, 1, 0)},
            '{8'h7A,      1'b1, ROW_RES,     mk_res(1, 8'h7A, 0, 1, 1, 1, 2, 0)},
            '{CHAR_LF,    1'b1, ROW_RES,     mk_res(0, 8'h00, 0, 0, 0, 1, 0, 0)},
            '{CHAR_SPACE, 1'b1, ROW_RES,     mk_res(0, 8'h00, 0, 0, 0, 1, 0, 0)}
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i])
            send_byte(dir_tab[i].b, dir_tab[i].last, dir_tab[i].kind, dir_tab[i].res);

        // Limit lines: one field past its length budget (raises the sticky flag),
        // then a line with more separators than the field budget allows.
        push_text(LEN_LIMIT + 6, 1'b0);
        line_bytes.push_back(CHAR_COMMA);
        line_bytes.push_back(8'h51);
        send_line();
        repeat (FIELD_LIMIT + 2) begin
            line_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
            line_bytes.push_back(CHAR_COMMA);
        end
        line_bytes.push_back(8'h58);
        send_line();

        // Random lines: mostly well-formed CSV with random content, with some long
        // fields, some overlong lines and some raw noise.
        while (rand_sent < RAND_BYTES) begin
            kind = $urandom_range(99);
            if (kind < 3) begin
                push_blanks($urandom_range(2));
                push_text($urandom_range(LEN_LIMIT - 8, LEN_LIMIT + 12), 1'b0);
                if ($urandom_range(1))
                    line_bytes.push_back(CHAR_COMMA);
            end else if (kind < 6) begin
                repeat ($urandom_range(FIELD_LIMIT - 1, FIELD_LIMIT + 3)) begin
                    push_text($urandom_range(2), 1'b0);
                    line_bytes.push_back(CHAR_COMMA);
                end
                push_text($urandom_range(2), 1'b0);
            end else if (kind < 88) begin
                nfld = $urandom_range(1, 6);
                for (int f = 0; f < nfld; f++) begin
                    quoted = $urandom_range(3) == 0;
                    push_blanks($urandom_range(2));
                    if (quoted)
                        line_bytes.push_back(CHAR_QUOTE);
                    push_text($urandom_range(8), quoted);
                    if (quoted)
                        line_bytes.push_back(CHAR_QUOTE);
                    push_blanks($urandom_range(2));
                    if (f != nfld - 1)
                        line_bytes.push_back(CHAR_COMMA);
                end
                if ($urandom_range(1)) begin
                    line_bytes.push_back(CHAR_CR);
                    line_bytes.push_back(CHAR_LF);
                end
            end else begin
                // noise, unbalanced quotes included
                repeat ($urandom_range(1, 20))
                    line_bytes.push_back(8'($urandom_range(255)));
            end
            if (line_bytes.size() == 0)
                line_bytes.push_back(CHAR_LF);
            send_line();
        end

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: csv_field_splitter_unit.f
+incdir+sv
sv/csvfs_pkg.sv
sv/csvfs_core.sv
sv/csvfs_out_reg.sv
sv/csv_field_splitter_unit.sv
dv/csv_field_splitter_unit_test.sv
